@@ rtl/tanh_overdrive_with_lowpass_tone_macros.svh @@
`ifndef TANH_OVERDRIVE_WITH_LOWPASS_TONE_MACROS_SVH
`define TANH_OVERDRIVE_WITH_LOWPASS_TONE_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset
`define TOD_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: %m");

// Next-cycle implication, sampled on the rising edge, off while in reset
`define TOD_ASSERT_NXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: %m");

`endif

@@ rtl/tanhod_pkg.sv @@
`timescale 1ns / 1ps

package tanhod_pkg;

  // sizing
  localparam int CHANNELS    = 2;
  localparam int TANH_DEPTH  = 256;
  localparam int TANH_AW     = $clog2(TANH_DEPTH);
  localparam int POS_W       = 26;
  localparam int FRAC_W      = POS_W - TANH_AW;
  localparam int DRIVE_LIMIT = 1 << POS_W;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRE_SCALE  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POST_SCALE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOWPASS_B0 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LOWPASS_A1 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LOWPASS_A2 = 3'd5;

  // opcodes
  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // register reset values
  localparam logic [22:0]        PRE_SCALE_RST  = 23'd78643;
  localparam logic [16:0]        POST_SCALE_RST = 17'd19654;
  localparam logic [30:0]        B0_RST         = 31'd2736800;
  localparam logic signed [31:0] A1_RST         = -32'sd1987389000;
  localparam logic signed [31:0] A2_RST         = 32'sd924536000;

  typedef logic [POS_W:0] tabs_t;

  typedef struct packed {
    logic              opcode;
    logic              channel;
    logic signed [23:0] sample_in;
  } in_t;

  typedef struct packed {
    logic              channel_out;
    logic signed [23:0] sample_out;
  } out_t;

  // datapath steps, one per working controller state; idle and emit give STEP_NONE
  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_DRIVE,
    STEP_TABLE,
    STEP_INTERP,
    STEP_SHAPE,
    STEP_LEVEL,
    STEP_B0,
    STEP_YSUM,
    STEP_A1,
    STEP_A2,
    STEP_WRITE,
    STEP_CLEAR
  } step_t;

  typedef struct packed {
    step_t step;
    logic  capture;
    logic  load_out;
    logic  bypass;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_bypass;
  } status_t;

  // tanh table, entry k holds tanh(8k/DEPTH) in Q1.23
  typedef logic [23:0] tanh_rom_t [0:TANH_DEPTH];

  // unsigned long division by shift and subtract, used while building the table
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t       rom;
    longint unsigned z;
    longint unsigned term;
    longint unsigned e;
    longint unsigned den;
    longint unsigned num;
    longint unsigned q31;
    longint          sum;
    for (int k = 0; k <= TANH_DEPTH; k++) begin
      q31  = 64'd1 << 31;
      z    = (longint'(k) << 30) / TANH_DEPTH;
      term = q31;
      sum  = longint'(q31);
      for (int n = 1; n <= 14; n++) begin
        term = udiv64((term * z) >> 31, 64'(n));
        if ((n & 1) != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      e = (sum < 0) ? 64'd0 : longint'(sum);
      for (int r = 0; r < 5; r++) begin
        e = (e * e + (64'd1 << 30)) >> 31;
      end
      den    = q31 + e;
      num    = (q31 - e) << 23;
      rom[k] = 24'(udiv64(num + (den >> 1), den));
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

@@ rtl/tanh_overdrive_with_lowpass_tone.sv @@
`timescale 1ns / 1ps

// Overdrive with tone low pass. Each Q1.23 sample is scaled by pre_scale,
// clamped to +-8, shaped by an interpolated tanh table, scaled by post_scale
// and filtered by a per-channel low pass biquad, then saturated to 24 bits.
// A clear item zeroes the filter state of every channel and gives no result;
// with enable low a sample passes unchanged. One item is worked at a time:
// a filtered sample steps through the drive, table, interp, shape, level,
// b0, ysum, a1, a2 and write states, the one 33x32 multiplier forming the
// six products in turn. A bypassed sample or a clear item takes only the emit
// or the clear state. The result sits in an output register, so a result that
// waits does not block the next item from being accepted. The user must write
// registers via cfg_write, cfg_index and cfg_data while idle (not enforced).
module tanh_overdrive_with_lowpass_tone (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_ready,
  input  tanhod_pkg::in_t                    sample_data,
  output logic                               result_valid,
  input  logic                               result_ready,
  output tanhod_pkg::out_t                   result_data,
  input  logic                               cfg_write,
  input  logic [tanhod_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tanhod_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tanhod_pkg::cmd_t    cmd;
  tanhod_pkg::status_t status;

  // sequence each item
  tanhod_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // arithmetic, registers and filter state
  tanhod_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_data (sample_data),
    .cmd         (cmd),
    .status      (status),
    .result_data (result_data)
  );

endmodule

@@ rtl/tanhod_ctrl.sv @@
`timescale 1ns / 1ps

module tanhod_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  output logic                result_valid,
  input  logic                result_ready,
  input  tanhod_pkg::status_t status,
  output tanhod_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DRIVE,
    S_TABLE,
    S_INTERP,
    S_SHAPE,
    S_LEVEL,
    S_B0,
    S_YSUM,
    S_A1,
    S_A2,
    S_WRITE,
    S_EMIT,
    S_CLEAR
  } state_t;

  state_t state;
  state_t state_next;
  logic   bypass;
  logic   bypass_next;
  logic   take;
  logic   load_out;

  assign sample_ready = (state == S_IDLE);
  assign take         = sample_valid && sample_ready;
  assign load_out     = (state == S_EMIT) && (!result_valid || result_ready);

  // sequence the steps of one item
  always_comb begin
    state_next  = state;
    bypass_next = bypass;
    case (state)
      S_IDLE: begin
        if (take) begin
          if (status.is_clear) begin
            state_next = S_CLEAR;
          end else if (status.is_bypass) begin
            state_next  = S_EMIT;
            bypass_next = 1'b1;
          end else begin
            state_next  = S_DRIVE;
            bypass_next = 1'b0;
          end
        end
      end
      S_DRIVE:  state_next = S_TABLE;
      S_TABLE:  state_next = S_INTERP;
      S_INTERP: state_next = S_SHAPE;
      S_SHAPE:  state_next = S_LEVEL;
      S_LEVEL:  state_next = S_B0;
      S_B0:     state_next = S_YSUM;
      S_YSUM:   state_next = S_A1;
      S_A1:     state_next = S_A2;
      S_A2:     state_next = S_WRITE;
      S_WRITE:  state_next = S_EMIT;
      S_EMIT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      S_CLEAR:  state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bypass       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state  <= state_next;
      bypass <= bypass_next;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // decode commands to the datapath
  always_comb begin
    cmd.capture  = take;
    cmd.load_out = load_out;
    cmd.bypass   = bypass;
    case (state)
      S_DRIVE:  cmd.step = tanhod_pkg::STEP_DRIVE;
      S_TABLE:  cmd.step = tanhod_pkg::STEP_TABLE;
      S_INTERP: cmd.step = tanhod_pkg::STEP_INTERP;
      S_SHAPE:  cmd.step = tanhod_pkg::STEP_SHAPE;
      S_LEVEL:  cmd.step = tanhod_pkg::STEP_LEVEL;
      S_B0:     cmd.step = tanhod_pkg::STEP_B0;
      S_YSUM:   cmd.step = tanhod_pkg::STEP_YSUM;
      S_A1:     cmd.step = tanhod_pkg::STEP_A1;
      S_A2:     cmd.step = tanhod_pkg::STEP_A2;
      S_WRITE:  cmd.step = tanhod_pkg::STEP_WRITE;
      S_CLEAR:  cmd.step = tanhod_pkg::STEP_CLEAR;
      default:  cmd.step = tanhod_pkg::STEP_NONE;
    endcase
  end

endmodule

@@ rtl/tanhod_dp.sv @@
`timescale 1ns / 1ps

module tanhod_dp (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  logic [tanhod_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [tanhod_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  tanhod_pkg::in_t                          sample_data,
  input  tanhod_pkg::cmd_t                         cmd,
  output tanhod_pkg::status_t                      status,
  output tanhod_pkg::out_t                         result_data
);

  function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
    if (v > 42'sd549755813887) begin
      return {1'b0, {39{1'b1}}};
    end else if (v < -42'sd549755813888) begin
      return {1'b1, 39'd0};
    end
    return v[39:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [32:0] v);
    if (v > 33'sd8388607) begin
      return {1'b0, {23{1'b1}}};
    end else if (v < -33'sd8388608) begin
      return {1'b1, 23'd0};
    end
    return v[23:0];
  endfunction

  // configuration registers
  logic                enable;
  logic [22:0]         pre_scale;
  logic [16:0]         post_scale;
  logic [30:0]         lowpass_b0;
  logic signed [31:0]  lowpass_a1;
  logic signed [31:0]  lowpass_a2;

  // item and working registers
  logic signed [23:0]           x_reg;
  logic                         ch_reg;
  logic signed [64:0]           prod;
  logic                         t_neg;
  logic                         at_end;
  logic [tanhod_pkg::FRAC_W-1:0] a_low;
  logic [23:0]                  rom_lo;
  logic signed [24:0]           rom_diff;
  logic signed [24:0]           v;
  logic signed [34:0]           p_hi;
  logic signed [40:0]           y;
  logic signed [32:0]           f;
  logic signed [39:0]           n1;

  // filter state per channel
  logic signed [39:0] s1 [tanhod_pkg::CHANNELS];
  logic signed [39:0] s2 [tanhod_pkg::CHANNELS];

  // combinational terms
  logic signed [32:0]           mul_a;
  logic signed [31:0]           mul_b;
  logic signed [48:0]           drv;
  logic [48:0]                  drv_mag;
  tanhod_pkg::tabs_t            t_abs;
  logic [tanhod_pkg::TANH_AW:0] idx_lo;
  logic [tanhod_pkg::TANH_AW:0] idx_hi;
  logic [23:0]                  rom_hi;
  logic signed [24:0]           interp_step;
  logic signed [24:0]           mag;
  logic signed [24:0]           w_cur;
  logic signed [39:0]           s1_rd;
  logic signed [39:0]           s2_rd;
  logic signed [40:0]           y_sum;
  logic signed [32:0]           f_cur;
  logic signed [41:0]           n1_sum;
  logic signed [41:0]           n2_sum;

  // classify the offered item
  assign status.is_clear  = (sample_data.opcode == tanhod_pkg::OP_CLEAR);
  assign status.is_bypass = !enable || (int'(sample_data.channel) >= tanhod_pkg::CHANNELS);

  // take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      pre_scale  <= tanhod_pkg::PRE_SCALE_RST;
      post_scale <= tanhod_pkg::POST_SCALE_RST;
      lowpass_b0 <= tanhod_pkg::B0_RST;
      lowpass_a1 <= tanhod_pkg::A1_RST;
      lowpass_a2 <= tanhod_pkg::A2_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        tanhod_pkg::REG_ENABLE:     enable     <= cfg_data[0];
        tanhod_pkg::REG_PRE_SCALE:  pre_scale  <= cfg_data[22:0];
        tanhod_pkg::REG_POST_SCALE: post_scale <= cfg_data[16:0];
        tanhod_pkg::REG_LOWPASS_B0: lowpass_b0 <= cfg_data[30:0];
        tanhod_pkg::REG_LOWPASS_A1: lowpass_a1 <= $signed(cfg_data);
        tanhod_pkg::REG_LOWPASS_A2: lowpass_a2 <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // drive clamp and table addressing
  assign drv     = $signed(prod[64:16]);
  assign drv_mag = drv[48] ? 49'(-drv) : 49'(drv);
  assign t_abs   = (drv_mag > 49'(tanhod_pkg::DRIVE_LIMIT)) ?
                   tanhod_pkg::tabs_t'(tanhod_pkg::DRIVE_LIMIT) :
                   drv_mag[tanhod_pkg::POS_W:0];
  assign idx_lo  = {1'b0, t_abs[tanhod_pkg::POS_W-1:tanhod_pkg::FRAC_W]};
  assign idx_hi  = idx_lo + (tanhod_pkg::TANH_AW + 1)'(1);
  assign rom_hi  = tanhod_pkg::TANH_ROM[idx_hi];

  // interpolation and sign restore
  assign interp_step = $signed(prod[tanhod_pkg::FRAC_W+24:tanhod_pkg::FRAC_W]);
  assign mag = at_end ? $signed({1'b0, tanhod_pkg::TANH_ROM[tanhod_pkg::TANH_DEPTH]}) :
                        $signed({1'b0, rom_lo}) + interp_step;

  // level and biquad terms
  assign w_cur  = $signed(prod[40:16]);
  assign s1_rd  = s1[ch_reg];
  assign s2_rd  = s2[ch_reg];
  assign y_sum  = 41'($signed(prod[55:22])) + 41'(s1_rd);
  assign f_cur  = (y_sum > 41'sd4294967295) ? 33'sd4294967295 :
                  (y_sum < -41'sd4294967295) ? -33'sd4294967295 : 33'(y_sum);
  assign n1_sum = 42'(p_hi) - 42'($signed(prod[64:30])) + 42'(s2_rd);
  assign n2_sum = 42'($signed(p_hi[34:1])) - 42'($signed(prod[64:30]));

  // select operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      tanhod_pkg::STEP_DRIVE: begin
        mul_a = 33'(x_reg);
        mul_b = 32'(pre_scale);
      end
      tanhod_pkg::STEP_INTERP: begin
        mul_a = 33'(rom_diff);
        mul_b = 32'(a_low);
      end
      tanhod_pkg::STEP_LEVEL: begin
        mul_a = 33'(v);
        mul_b = 32'(post_scale);
      end
      tanhod_pkg::STEP_B0: begin
        mul_a = 33'(w_cur);
        mul_b = 32'(lowpass_b0);
      end
      tanhod_pkg::STEP_A1: begin
        mul_a = f;
        mul_b = lowpass_a1;
      end
      tanhod_pkg::STEP_A2: begin
        mul_a = f;
        mul_b = lowpass_a2;
      end
      default: ;
    endcase
  end

  // advance the working registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.capture) begin
      x_reg  <= sample_data.sample_in;
      ch_reg <= sample_data.channel;
    end
    case (cmd.step)
      tanhod_pkg::STEP_TABLE: begin
        t_neg    <= drv[48];
        at_end   <= t_abs[tanhod_pkg::POS_W];
        a_low    <= t_abs[tanhod_pkg::FRAC_W-1:0];
        rom_lo   <= tanhod_pkg::TANH_ROM[idx_lo];
        rom_diff <= $signed({1'b0, rom_hi}) - $signed({1'b0, tanhod_pkg::TANH_ROM[idx_lo]});
      end
      tanhod_pkg::STEP_SHAPE: begin
        v <= t_neg ? -mag : mag;
      end
      tanhod_pkg::STEP_YSUM: begin
        p_hi <= $signed(prod[55:21]);
        y    <= y_sum;
        f    <= f_cur;
      end
      tanhod_pkg::STEP_A2: begin
        n1 <= sat40(n1_sum);
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      result_data.channel_out <= ch_reg;
      result_data.sample_out  <= cmd.bypass ? x_reg : sat24(y[40:8]);
    end
  end

  // update or clear the filter state
  always_ff @(posedge clk) begin
    if (rst || (cmd.step == tanhod_pkg::STEP_CLEAR)) begin
      for (int i = 0; i < tanhod_pkg::CHANNELS; i++) begin
        s1[i] <= '0;
        s2[i] <= '0;
      end
    end else if (cmd.step == tanhod_pkg::STEP_WRITE) begin
      s1[ch_reg] <= n1;
      s2[ch_reg] <= sat40(n2_sum);
    end
  end

endmodule

@@ rtl/tanhod_checker.sv @@
`timescale 1ns / 1ps
`include "tanh_overdrive_with_lowpass_tone_macros.svh"

module tanhod_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               sample_valid,
  input logic                               sample_ready,
  input tanhod_pkg::in_t                    sample_data,
  input logic                               result_valid,
  input logic                               result_ready,
  input tanhod_pkg::out_t                   result_data
);

  logic take;
  logic take_clear;

  assign take       = sample_valid && sample_ready;
  assign take_clear = take && (sample_data.opcode == tanhod_pkg::OP_CLEAR);

  // one item at a time: busy right after a transfer in
  `TOD_ASSERT_NXT(a_busy_after_take, clk, rst, take, !sample_ready)

  // a clear item never raises a result
  `TOD_ASSERT_NXT(a_clear_silent, clk, rst, take_clear && !result_valid, !result_valid)

  // a new result only comes out of a busy cycle
  `TOD_ASSERT_IMP(a_result_from_busy, clk, rst, $rose(result_valid), !$past(sample_ready))

  // a stalled result holds
  `TOD_ASSERT_NXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result_data))

endmodule

bind tanh_overdrive_with_lowpass_tone tanhod_checker u_checker (.*);
